@@ sv/stpm_pkg.sv @@
package stpm_pkg;

    localparam int SLOT_BYTES = 16;
    localparam int KEY_W      = 8 * SLOT_BYTES;
    localparam int HALF_W     = KEY_W / 2;
    localparam int IDX_W      = 4;
    localparam int TLEN_W     = 8;
    localparam int SLEN_W     = 5;
    localparam int UPOS_W     = 4;
    localparam int OP_W       = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam int S_DATA_W   = 152;
    localparam int M_DATA_W   = 16;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   text;
        logic [TLEN_W-1:0]  len;
        logic [UPOS_W-1:0]  upos;
        logic [7:0]         ubyte;
    } cmd_t;

endpackage

@@ sv/stpm_front.sv @@
module stpm_front #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [stpm_pkg::S_DATA_W-1:0]     s_axis_tdata,
    input  logic [stpm_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                              push_valid,
    input  logic                              push_ready,
    output stpm_pkg::cmd_t                    push_cmd
);

    logic [stpm_pkg::IDX_W-1:0]  idx;
    logic [stpm_pkg::TLEN_W-1:0] len;
    logic                        idx_ok;
    logic                        keep;

    assign idx    = s_axis_tdata[3:0];
    assign len    = s_axis_tdata[139:132];
    assign idx_ok = 32'(idx) < NUM_SLOTS;

    always_comb begin
        push_cmd.idx   = idx;
        push_cmd.text  = s_axis_tdata[131:4];
        push_cmd.len   = len;
        push_cmd.upos  = s_axis_tdata[143:140];
        push_cmd.ubyte = s_axis_tdata[151:144];
        push_cmd.kind  = stpm_pkg::KIND_SEARCH;
        keep           = 1'b0;
        case (s_axis_tuser)
            stpm_pkg::OP_SEARCH: begin
                keep = 1'b1;
            end
            stpm_pkg::OP_WRITE: begin
                keep = idx_ok;
                // oversize slots are not supported, treated as a clear
                push_cmd.kind = (32'(len) > stpm_pkg::SLOT_BYTES) ?
                                stpm_pkg::KIND_CLEAR : stpm_pkg::KIND_WRITE;
            end
            stpm_pkg::OP_CLEAR: begin
                keep          = idx_ok;
                push_cmd.kind = stpm_pkg::KIND_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid && keep;

endmodule

@@ sv/stpm_queue.sv @@
module stpm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  stpm_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output stpm_pkg::cmd_t  pop_cmd
);

    stpm_pkg::cmd_t                  entry_reg [stpm_pkg::Q_DEPTH];
    logic [stpm_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [stpm_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [stpm_pkg::Q_CNT_W-1:0]    count_reg, count_next;
    logic                            push;
    logic                            pop;

    assign push_ready = count_reg != stpm_pkg::Q_CNT_W'(stpm_pkg::Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == stpm_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == stpm_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= stpm_pkg::Q_DEPTH)
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

@@ sv/stpm_back.sv @@
module stpm_back #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  stpm_pkg::cmd_t                cmd,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [stpm_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser
);

    logic [stpm_pkg::KEY_W-1:0]  text_reg  [NUM_SLOTS];
    logic [stpm_pkg::SLEN_W-1:0] len_reg   [NUM_SLOTS];
    logic [stpm_pkg::UPOS_W-1:0] upos_reg  [NUM_SLOTS];
    logic [7:0]                  uval_reg  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]        used_reg;

    logic [NUM_SLOTS-1:0]        hit;
    logic [NUM_SLOTS-1:0]        hit_reg;
    logic                        cmp_valid_reg;
    logic                        cmp_advance;
    logic                        pop;
    logic                        is_search;

    logic                        enc_found;
    logic [stpm_pkg::IDX_W-1:0]  enc_slot;
    logic [stpm_pkg::SLEN_W-1:0] enc_count;

    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [stpm_pkg::IDX_W-1:0]  out_slot_reg;
    logic [stpm_pkg::SLEN_W-1:0] out_count_reg;

    assign is_search   = cmd.kind == stpm_pkg::KIND_SEARCH;
    assign cmp_advance = cmp_valid_reg && (!out_valid_reg || m_axis_tready);
    // table updates wait until no search holds the compare stage
    assign cmd_ready   = is_search ? (!cmp_valid_reg || cmp_advance) : !cmp_valid_reg;
    assign pop         = cmd_valid && cmd_ready;

    for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
        logic [stpm_pkg::SLOT_BYTES-1:0] byte_ok;
        logic                            sel;

        assign sel = 32'(cmd.idx) == s;

        always_comb begin
            for (int k = 0; k < stpm_pkg::SLOT_BYTES; k++) begin
                byte_ok[k] = (k >= 32'(len_reg[s])) ||
                             (text_reg[s][8*k +: 8] == cmd.text[8*k +: 8]);
            end
        end

        assign hit[s] = used_reg[s] &&
                        ({3'b000, len_reg[s]} <= cmd.len) &&
                        (cmd.text[8*upos_reg[s] +: 8] == uval_reg[s]) &&
                        (&byte_ok);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                used_reg[s] <= 1'b0;
            end else if (pop && sel && !is_search) begin
                used_reg[s] <= cmd.kind == stpm_pkg::KIND_WRITE;
            end
        end

        always_ff @(posedge aclk) begin
            if (pop && sel && cmd.kind == stpm_pkg::KIND_WRITE) begin
                text_reg[s] <= cmd.text;
                len_reg[s]  <= cmd.len[stpm_pkg::SLEN_W-1:0];
                upos_reg[s] <= cmd.upos;
                uval_reg[s] <= cmd.ubyte;
            end
        end
    end

    always_comb begin
        enc_found = 1'b0;
        enc_slot  = '0;
        enc_count = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                enc_found = 1'b1;
                enc_slot  = stpm_pkg::IDX_W'(i);
                enc_count = len_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop && is_search) begin
                cmp_valid_reg <= 1'b1;
            end else if (cmp_advance) begin
                cmp_valid_reg <= 1'b0;
            end
            if (cmp_advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && is_search) begin
            hit_reg <= hit;
        end
        if (cmp_advance) begin
            out_found_reg <= enc_found;
            out_slot_reg  <= enc_slot;
            out_count_reg <= enc_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {7'b0000000, out_count_reg, out_slot_reg};

`ifndef SYNTHESIS
    a_no_update_under_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && !is_search && cmp_valid_reg) |-> !pop)
        else $error("table changed while a search was in flight");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_slot_reg == '0 && out_count_reg == '0))
        else $error("miss result carries nonzero fields");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (32'(out_count_reg) <= stpm_pkg::SLOT_BYTES))
        else $error("matched count exceeds slot size");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_advance |=> out_valid_reg)
        else $error("compared search produced no result");
`endif

endmodule

@@ sv/string_table_prefix_match_top.sv @@
// Prefix lookup over a table of NUM_SLOTS short strings (up to 16 bytes each).
// Items arrive on the s_axis stream; tuser carries the opcode (search, write
// slot, clear slot). Writes and clears update one slot and produce no transfer
// on m_axis; each search produces exactly one transfer giving the lowest used
// slot whose text is a prefix of the key and whose distinguishing byte agrees.
// Slot used flags clear at reset; no clearing pass is needed. Accepted items
// sit in a two-entry queue ahead of the compare stage, so behind a waiting
// result the input takes one more search into the compare stage and two into
// the queue before it stalls.
// A search goes through the parallel compare of all slots into the compare
// stage register and then through the priority encoder into the result
// register; searches stream at one per cycle while m_axis accepts results.
// A write or clear waits until the compare stage is empty.
module string_table_prefix_match_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // slot_index, bytes_low, bytes_high, text_length, unique_position, unique_byte
    input  logic [151:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // match_slot, matched_count, zero fill
    output logic [15:0]   m_axis_tdata,
    // found
    output logic          m_axis_tuser
);

    logic           push_valid;
    logic           push_ready;
    stpm_pkg::cmd_t push_cmd;
    logic           cmd_valid;
    logic           cmd_ready;
    stpm_pkg::cmd_t cmd;

    stpm_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    stpm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    stpm_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ dv/string_table_prefix_match_top_tb.sv @@
`timescale 1ns / 1ps

module string_table_prefix_match_top_tb;

    localparam logic [stpm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NSLOT        = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1000;

    typedef enum int {
        RX_ALWAYS,
        RX_SPARSE,
        RX_PERIODIC,
        RX_HEAVY
    } rx_mode_t;

    typedef struct packed {
        logic                        found;
        logic [stpm_pkg::IDX_W-1:0]  slot;
        logic [stpm_pkg::SLEN_W-1:0] count;
    } lookup_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [151:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [15:0]   m_axis_tdata;
    logic          m_axis_tuser;

    logic [stpm_pkg::KEY_W-1:0]  tbl_text  [NSLOT];
    logic [stpm_pkg::SLEN_W-1:0] tbl_len   [NSLOT];
    logic                        tbl_used  [NSLOT];
    logic [stpm_pkg::UPOS_W-1:0] tbl_upos  [NSLOT];
    logic [7:0]                  tbl_ubyte [NSLOT];

    lookup_result_t pending_lookups[$];

    int       burst_left  = 0;
    bit       gaps_on     = 1'b1;
    rx_mode_t stall_mode  = RX_ALWAYS;
    int       hold_cycles = 0;
    int       cycle_count = 0;
    int       error_count = 0;
    int       n_search = 0, n_hit = 0, n_write = 0, n_clear = 0, n_ignored = 0;
    int       n_checked = 0;

    string_table_prefix_match_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("string_table_prefix_match_top regression: fail");
            $finish;
        end
    end

    function automatic lookup_result_t lookup_prefix(
        input logic [stpm_pkg::KEY_W-1:0] key,
        input logic [stpm_pkg::TLEN_W-1:0] klen);
        lookup_result_t r;
        logic ok;
        r = '0;
        // scan downward so the lowest matching slot wins
        for (int s = NSLOT - 1; s >= 0; s--) begin
            if (tbl_used[s] && tbl_len[s] <= klen &&
                key[8*tbl_upos[s] +: 8] == tbl_ubyte[s]) begin
                ok = 1'b1;
                for (int k = 0; k < stpm_pkg::SLOT_BYTES; k++) begin
                    if (k < tbl_len[s] && tbl_text[s][8*k +: 8] != key[8*k +: 8])
                        ok = 1'b0;
                end
                if (ok) begin
                    r.found = 1'b1;
                    r.slot  = s[stpm_pkg::IDX_W-1:0];
                    r.count = tbl_len[s];
                end
            end
        end
        return r;
    endfunction

    task automatic apply_item(input logic [stpm_pkg::OP_W-1:0] op,
                              input logic [stpm_pkg::IDX_W-1:0] idx,
                              input logic [stpm_pkg::KEY_W-1:0] text,
                              input logic [stpm_pkg::TLEN_W-1:0] len,
                              input logic [stpm_pkg::UPOS_W-1:0] upos,
                              input logic [7:0] ub);
        lookup_result_t r;
        case (op)
            stpm_pkg::OP_SEARCH: begin
                r = lookup_prefix(text, len);
                pending_lookups.push_back(r);
                n_search++;
                if (r.found)
                    n_hit++;
            end
            stpm_pkg::OP_WRITE: begin
                n_write++;
                if (len > stpm_pkg::SLOT_BYTES) begin
                    tbl_used[idx] = 1'b0;
                end else begin
                    tbl_text[idx]  = text;
                    tbl_len[idx]   = len[stpm_pkg::SLEN_W-1:0];
                    tbl_upos[idx]  = upos;
                    tbl_ubyte[idx] = ub;
                    tbl_used[idx]  = 1'b1;
                end
            end
            stpm_pkg::OP_CLEAR: begin
                n_clear++;
                tbl_used[idx] = 1'b0;
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic send_item(input logic [stpm_pkg::OP_W-1:0] op,
                             input logic [stpm_pkg::IDX_W-1:0] idx,
                             input logic [stpm_pkg::HALF_W-1:0] lo,
                             input logic [stpm_pkg::HALF_W-1:0] hi,
                             input logic [stpm_pkg::TLEN_W-1:0] len,
                             input logic [stpm_pkg::UPOS_W-1:0] upos,
                             input logic [7:0] ub);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ub, upos, len, hi, lo, idx};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        apply_item(op, idx, {hi, lo}, len, upos, ub);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_item();
        logic [stpm_pkg::OP_W-1:0]   op;
        logic [stpm_pkg::IDX_W-1:0]  idx;
        logic [stpm_pkg::KEY_W-1:0]  text;
        logic [stpm_pkg::TLEN_W-1:0] len;
        logic [stpm_pkg::UPOS_W-1:0] upos;
        logic [7:0]                  ub;
        int pick, src, n;
        pick = $urandom_range(0, 99);
        text = {$urandom, $urandom, $urandom, $urandom};
        // narrow alphabet so slots share prefixes
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < stpm_pkg::SLOT_BYTES; k++)
                text[8*k +: 8] = 8'(8'h41 + $urandom_range(0, 1));
        end
        idx  = stpm_pkg::IDX_W'($urandom_range(0, NSLOT - 1));
        upos = stpm_pkg::UPOS_W'($urandom_range(0, 15));
        ub   = 8'($urandom_range(0, 255));
        len  = stpm_pkg::TLEN_W'($urandom_range(0, stpm_pkg::SLOT_BYTES));
        op   = stpm_pkg::OP_SEARCH;
        src  = $urandom_range(0, NSLOT - 1);
        for (int t = 0; t < 4 && !tbl_used[src]; t++)
            src = $urandom_range(0, NSLOT - 1);
        if (pick < 55) begin
            if (tbl_used[src]) begin
                n = int'(tbl_len[src]);
                for (int k = 0; k < n; k++)
                    text[8*k +: 8] = tbl_text[src][8*k +: 8];
                if (tbl_upos[src] >= n)
                    text[8*tbl_upos[src] +: 8] = tbl_ubyte[src];
                if ($urandom_range(0, 4) == 0)
                    len = stpm_pkg::TLEN_W'($urandom_range(n, 255));
                else
                    len = stpm_pkg::TLEN_W'($urandom_range(n, stpm_pkg::SLOT_BYTES));
            end
        end else if (pick < 65) begin
            len = stpm_pkg::TLEN_W'($urandom_range(0, 255));
        end else if (pick < 90) begin
            op = stpm_pkg::OP_WRITE;
            if (tbl_used[src] && $urandom_range(0, 1) == 1) begin
                n = int'(tbl_len[src]);
                for (int k = 0; k < n; k++)
                    text[8*k +: 8] = tbl_text[src][8*k +: 8];
            end
            if ($urandom_range(0, 9) == 0)
                len = stpm_pkg::TLEN_W'($urandom_range(stpm_pkg::SLOT_BYTES + 1, 255));
            if ($urandom_range(0, 9) < 7)
                ub = text[8*upos +: 8];
        end else if (pick < 97) begin
            op = stpm_pkg::OP_CLEAR;
        end else begin
            op = OP_UNUSED;
        end
        send_item(op, idx, text[stpm_pkg::HALF_W-1:0],
                  text[stpm_pkg::KEY_W-1:stpm_pkg::HALF_W], len, upos, ub);
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_axis_tready <= ((cycle_count % 7) > 2);
                default:     m_axis_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result transfer: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_lookups.pop_front();
                n_checked++;
                if (m_axis_tuser !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[3:0] !== want.slot) begin
                    $error("match_slot: expected %0d actual %0d",
                           want.slot, m_axis_tdata[3:0]);
                    error_count++;
                end
                if (m_axis_tdata[8:4] !== want.count) begin
                    $error("matched_count: expected %0d actual %0d",
                           want.count, m_axis_tdata[8:4]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        gaps_on    = 1'b0;
        stall_mode = RX_SPARSE;
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '0, '0, 8'd0, 4'd0, 8'h00);
        // zero-length slot
        send_item(stpm_pkg::OP_WRITE, 4'd0, '0, '0, 8'd0, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '0, '0, 8'd0, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'hff, '0, 8'd5, 4'd0, 8'h00);
        // full 16-byte slot
        send_item(stpm_pkg::OP_WRITE, 4'hf, '1, '1, 8'd16, 4'hf, 8'hff);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '1, '1, 8'd16, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '1, '1, 8'd255, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '1, '1, 8'd15, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'hffff_ffff_ffff_ff00, '1, 8'd255, 4'd0, 8'h00);
        // over-long writes leave the slot unused
        send_item(stpm_pkg::OP_WRITE, 4'd3, 64'h4443_4241, '0, 8'd17, 4'd0, 8'h41);
        send_item(stpm_pkg::OP_WRITE, 4'd3, 64'h4443_4241, '0, 8'd255, 4'd0, 8'h41);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'h4443_4241, '0, 8'd4, 4'd0, 8'h00);
        // distinguishing byte beyond the key length
        send_item(stpm_pkg::OP_WRITE, 4'd5, 64'h4241, '0, 8'd2, 4'd10, 8'h5a);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'h4241, 64'h5a_0000, 8'd2, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'h4241, '0, 8'd2, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'h4241, 64'h5a_0000, 8'd1, 4'd0, 8'h00);
        send_item(OP_UNUSED, 4'hf, '1, '1, 8'hff, 4'hf, 8'hff);
        send_item(stpm_pkg::OP_CLEAR, 4'd0, '0, '0, 8'd0, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '0, '0, 8'd0, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_CLEAR, 4'hf, '1, '1, 8'hff, 4'hf, 8'hff);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, '1, '1, 8'd16, 4'd0, 8'h00);
        send_item(stpm_pkg::OP_WRITE, 4'd1, 64'h4241, '0, 8'd1, 4'd0, 8'h41);
        send_item(stpm_pkg::OP_SEARCH, 4'd0, 64'h4241, 64'h5a_0000, 8'd2, 4'd0, 8'h00);
        wait_drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                gaps_on    = ($urandom_range(0, 2) != 0);
            end
            random_item();
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        gaps_on     = 1'b0;
        stall_mode  = RX_ALWAYS;
        hold_cycles = 120;
        repeat (40) random_item();
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        stall_mode = RX_HEAVY;
        repeat (5) begin
            repeat (8) random_item();
            wait_drain();
        end
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++)
            tbl_used[s] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random(RANDOM_ITEMS);
        test_drain_pause();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d searches (%0d hits), %0d slot writes, %0d clears, %0d ignored",
                 n_search, n_hit, n_write, n_clear, n_ignored);
        $display("%0d result transfers checked with random bursts, stalls and a long hold",
                 n_checked);
        if (error_count == 0) begin
            $display("string_table_prefix_match_top regression: pass");
        end else begin
            $display("string_table_prefix_match_top regression: fail");
        end
        $finish;
    end

endmodule
